// ===== rtl/core/size_class_slot_allocator_core_assert.svh =====
// Assertion macros for the slot allocator core
`ifndef SIZE_CLASS_SLOT_ALLOCATOR_CORE_ASSERT_SVH
`define SIZE_CLASS_SLOT_ALLOCATOR_CORE_ASSERT_SVH
`ifndef SYNTHESIS
// Check prop at every clock edge outside reset
`define SCA_ASSERT(label, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("sca assertion failed");
// Check that cons holds in the cycle after ante
`define SCA_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sca assertion failed");
`else
`define SCA_ASSERT(label, prop)
`define SCA_ASSERT_NEXT(label, ante, cons)
`endif
`endif

// ===== rtl/core/sca_pkg.sv =====
// Shared types, constants and size class mapping for the slot allocator
`timescale 1ns / 1ps

package sca_pkg;

    localparam int SCA_SLOT_COUNT = 16;
    localparam int SCA_SLOT_BYTES = 18400;

    localparam logic [31:0] LIMIT_ONE  = 32'h0000_47E1;
    localparam logic [31:0] LIMIT_TWO  = 32'h0000_8FC0;
    localparam logic [31:0] LIMIT_FOUR = 32'h0001_1F80;

    localparam logic [3:0] CLASS_ONE   = 4'd1;
    localparam logic [3:0] CLASS_TWO   = 4'd2;
    localparam logic [3:0] CLASS_FOUR  = 4'd4;
    localparam logic [3:0] CLASS_EIGHT = 4'd8;

    localparam logic CMD_ALLOC   = 1'b0;
    localparam logic CMD_RELEASE = 1'b1;

    localparam logic [2:0] REG_BASE_ADDRESS = 3'd0;

    typedef struct packed {
        logic        cmd;
        logic [31:0] request_bytes;
        logic [3:0]  release_slot;
    } sca_req_t;

    typedef struct packed {
        logic        granted;
        logic [3:0]  slot_index;
        logic [31:0] block_address;
    } sca_rsp_t;

    function automatic logic [3:0] size_class(input logic [31:0] bytes);
        logic [3:0] cls;
        if (bytes < LIMIT_ONE)
            cls = CLASS_ONE;
        else if (bytes <= LIMIT_TWO)
            cls = CLASS_TWO;
        else if (bytes <= LIMIT_FOUR)
            cls = CLASS_FOUR;
        else
            cls = CLASS_EIGHT;
        return cls;
    endfunction

endpackage

// ===== rtl/core/sca_slot_table.sv =====
// Slot busy flags and run length memory for the slot allocator
`timescale 1ns / 1ps

module sca_slot_table
    import sca_pkg::*;
#(
    parameter int SLOT_COUNT = SCA_SLOT_COUNT
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          set_en,
    input  logic [$clog2(SLOT_COUNT)-1:0] set_idx,
    input  logic [3:0]                    set_len,
    input  logic                          clr_en,
    input  logic [$clog2(SLOT_COUNT)-1:0] clr_idx,
    input  logic [$clog2(SLOT_COUNT)-1:0] rd_idx,
    output logic [3:0]                    rd_len,
    output logic [SLOT_COUNT-1:0]         busy_vec
);

    logic [SLOT_COUNT-1:0] busy_reg;
    logic [3:0]            len_mem [SLOT_COUNT];
    logic [3:0]            rd_len_reg;

    // Busy flags clear at reset; run lengths are only read behind a busy flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= '0;
        end
        else
        begin
            if (set_en)
            begin
                busy_reg[set_idx] <= 1'b1;
            end
            if (clr_en)
            begin
                busy_reg[clr_idx] <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (set_en)
        begin
            len_mem[set_idx] <= set_len;
        end
        rd_len_reg <= len_mem[rd_idx];
    end

    assign rd_len   = rd_len_reg;
    assign busy_vec = busy_reg;

endmodule

// ===== rtl/core/size_class_slot_allocator_core.sv =====
// Top level of the size class slot allocator: sequencer, scan unit and config port
// Release: result strobe in the cycle after start; busy never rises, so one per cycle.
// Allocate: each head is checked in ST_HEAD, and a busy head passes through ST_SKIP; a free
//   head leads to ST_RUN, which probes its run one slot at a time; ST_MUL, ST_ADD form the address.
// One transaction in flight; the next start is taken in the strobe cycle; no output stall.
// Reset (rst_n low, asynchronous) frees every slot and clears base_address to zero.
`timescale 1ns / 1ps

module size_class_slot_allocator_core
    import sca_pkg::*;
#(
    parameter int SLOT_COUNT = SCA_SLOT_COUNT,
    parameter int SLOT_BYTES = SCA_SLOT_BYTES
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  sca_req_t    req,
    output logic        busy,
    output logic        done,
    output sca_rsp_t    rsp,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

`include "size_class_slot_allocator_core_assert.svh"

    localparam int SLOT_W = $clog2(SLOT_COUNT);
    // scan index can run past the last slot by up to one largest class
    localparam int IDX_W  = $clog2(SLOT_COUNT + 8);
    localparam logic [IDX_W-1:0] IDX_LIMIT    = IDX_W'(SLOT_COUNT);
    localparam logic [31:0]      SLOT_BYTES_C = 32'(SLOT_BYTES);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_HEAD,
        ST_SKIP,
        ST_RUN,
        ST_MUL,
        ST_ADD
    } state_t;

    state_t           state_reg, state_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic [IDX_W-1:0] probe_reg, probe_next;
    logic [3:0]       remain_reg, remain_next;
    logic [3:0]       cls_reg, cls_next;
    logic [31:0]      prod_reg, prod_next;
    logic             done_reg, done_next;
    sca_rsp_t         rsp_reg, rsp_next;
    logic [31:0]      base_reg;

    logic                  set_en;
    logic                  clr_en;
    logic [SLOT_W-1:0]     clr_idx;
    logic [3:0]            rd_len;
    logic [SLOT_COUNT-1:0] busy_vec;

    logic             head_busy;
    logic             probe_taken;
    logic             rel_in_range;
    logic [3:0]       skip_len;
    logic [IDX_W-1:0] add_a;
    logic [IDX_W-1:0] add_b;
    logic [IDX_W-1:0] add_sum;

    // ---------------------------------------------------------------
    // Configuration port: one register, base_address, at byte 0
    // ---------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg <= '0;
        end
        else if (psel && penable && pwrite && (paddr == REG_BASE_ADDRESS))
        begin
            base_reg <= pwdata;
        end
    end

    assign prdata = (paddr == REG_BASE_ADDRESS) ? base_reg : 32'd0;
    assign pready = 1'b1;

    // ---------------------------------------------------------------
    // Slot state
    // ---------------------------------------------------------------
    assign rel_in_range = ({28'd0, req.release_slot} < 32'(SLOT_COUNT));
    assign clr_en       = (state_reg == ST_IDLE) && start
                          && (req.cmd == CMD_RELEASE) && rel_in_range;
    assign clr_idx      = SLOT_W'({28'd0, req.release_slot});
    // mark the run head once every slot of the run has checked out free
    assign set_en       = (state_reg == ST_RUN) && (remain_reg == 4'd0);

    sca_slot_table #(
        .SLOT_COUNT (SLOT_COUNT)
    ) u_table (
        .clk      (clk),
        .rst_n    (rst_n),
        .set_en   (set_en),
        .set_idx  (idx_reg[SLOT_W-1:0]),
        .set_len  (cls_reg),
        .clr_en   (clr_en),
        .clr_idx  (clr_idx),
        .rd_idx   (idx_reg[SLOT_W-1:0]),
        .rd_len   (rd_len),
        .busy_vec (busy_vec)
    );

    // An index at or past the pool end counts as taken
    assign head_busy   = busy_vec[idx_reg[SLOT_W-1:0]];
    assign probe_taken = (probe_reg >= IDX_LIMIT) || busy_vec[probe_reg[SLOT_W-1:0]];

    // ---------------------------------------------------------------
    // Shared index adder: skip over a busy head, skip a blocked run,
    // or advance the run probe by one slot
    // ---------------------------------------------------------------
    assign skip_len = (cls_reg < rd_len) ? rd_len : cls_reg;

    always_comb
    begin
        add_a = idx_reg;
        add_b = IDX_W'(cls_reg);
        if (state_reg == ST_SKIP)
        begin
            add_b = IDX_W'(skip_len);
        end
        else if ((state_reg == ST_RUN) && !probe_taken)
        begin
            add_a = probe_reg;
            add_b = IDX_W'(1);
        end
    end

    assign add_sum = add_a + add_b;

    // ---------------------------------------------------------------
    // Sequencer
    // ---------------------------------------------------------------
    always_comb
    begin
        state_next  = state_reg;
        idx_next    = idx_reg;
        probe_next  = probe_reg;
        remain_next = remain_reg;
        cls_next    = cls_reg;
        prod_next   = prod_reg;
        done_next   = 1'b0;
        rsp_next    = rsp_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    if (req.cmd == CMD_RELEASE)
                    begin
                        // release completes at once; out-of-range slots are ignored
                        done_next              = 1'b1;
                        rsp_next.granted       = rel_in_range;
                        rsp_next.slot_index    = req.release_slot;
                        rsp_next.block_address = 32'd0;
                    end
                    else
                    begin
                        cls_next   = size_class(req.request_bytes);
                        idx_next   = '0;
                        state_next = ST_HEAD;
                    end
                end
            end

            ST_HEAD:
            begin
                if (idx_reg >= IDX_LIMIT)
                begin
                    // scan ran off the end: report failure
                    done_next              = 1'b1;
                    rsp_next.granted       = 1'b0;
                    rsp_next.slot_index    = 4'd0;
                    rsp_next.block_address = 32'd0;
                    state_next             = ST_IDLE;
                end
                else if (head_busy)
                begin
                    // run length read is in flight; use it next cycle
                    state_next = ST_SKIP;
                end
                else
                begin
                    probe_next  = idx_reg;
                    remain_next = cls_reg;
                    state_next  = ST_RUN;
                end
            end

            ST_SKIP:
            begin
                idx_next   = add_sum;
                state_next = ST_HEAD;
            end

            ST_RUN:
            begin
                if (remain_reg == 4'd0)
                begin
                    state_next = ST_MUL;
                end
                else if (probe_taken)
                begin
                    idx_next   = add_sum;
                    state_next = ST_HEAD;
                end
                else
                begin
                    probe_next  = add_sum;
                    remain_next = remain_reg - 4'd1;
                end
            end

            ST_MUL:
            begin
                prod_next  = 32'(idx_reg) * SLOT_BYTES_C;
                state_next = ST_ADD;
            end

            ST_ADD:
            begin
                done_next              = 1'b1;
                rsp_next.granted       = 1'b1;
                rsp_next.slot_index    = idx_reg[3:0];
                rsp_next.block_address = base_reg + prod_reg;
                state_next             = ST_IDLE;
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    // scan datapath and result payload hold without reset
    always_ff @(posedge clk)
    begin
        idx_reg    <= idx_next;
        probe_reg  <= probe_next;
        remain_reg <= remain_next;
        cls_reg    <= cls_next;
        prod_reg   <= prod_next;
        rsp_reg    <= rsp_next;
    end

    assign busy = (state_reg != ST_IDLE);
    assign done = done_reg;
    assign rsp  = rsp_reg;

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    `SCA_ASSERT_NEXT(a_release_done, start && !busy && (req.cmd == CMD_RELEASE), done)
    `SCA_ASSERT_NEXT(a_alloc_goes_busy, start && !busy && (req.cmd == CMD_ALLOC), busy)
    `SCA_ASSERT(a_fail_zero_addr, (done && !rsp.granted) |-> (rsp.block_address == 32'd0))
    `SCA_ASSERT(a_no_set_and_clear, !(set_en && clr_en))

endmodule

// ===== tb/size_class_slot_allocator_core_tb.sv =====
// Self-checking testbench for the size class slot allocator core
`timescale 1ns / 1ps

module size_class_slot_allocator_core_tb;

    import sca_pkg::*;

    // Cycles with no accepted transaction, no result and no register access before giving up
    localparam int QUIET_LIMIT  = 2000;
    // Settle time after the last result, well above the longest allocate scan
    localparam int DRAIN_CYCLES = 60;
    // Chance, in percent, that the sender holds off a pending request in a given cycle
    localparam int IDLE_PCT     = 31;

    logic        clk     = 1'b0;
    logic        rst_n   = 1'b0;
    logic        start   = 1'b0;
    sca_req_t    req     = '0;
    logic        busy;
    logic        done;
    sca_rsp_t    rsp;
    logic        psel    = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite  = 1'b0;
    logic [2:0]  paddr   = '0;
    logic [31:0] pwdata  = '0;
    logic [31:0] prdata;
    logic        pready;

    // Requests waiting to be driven, and outcomes waiting to come back, oldest first
    sca_req_t    pending_cmds[$];
    sca_rsp_t    expected_grants[$];

    // Shadow of the pool: busy run heads, their run lengths and the buffer base
    logic        pool_busy    [SCA_SLOT_COUNT];
    logic [3:0]  pool_run_len [SCA_SLOT_COUNT];
    logic [31:0] pool_base = '0;

    bit          idle_on = 1'b1;
    int          mismatch_count = 0;
    int          quiet_cycles = 0;

    size_class_slot_allocator_core dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .req     (req),
        .busy    (busy),
        .done    (done),
        .rsp     (rsp),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Compute the outcome of one accepted transaction and advance the shadow pool.
    // Allocate: map the size to a class, then run a first-fit scan from slot 0.
    // A busy head skips by the larger of its run length and the class; a free
    // index whose run hits a busy slot or the end of the pool skips by the class.
    function automatic sca_rsp_t predict_grant(input sca_req_t r);
        sca_rsp_t g;
        int       idx;
        int       cls;
        int       k;
        bit       run_ok;
        g = '0;
        if (r.cmd == CMD_RELEASE)
        begin
            // Release reports the slot it was given, even when that slot was free
            g.slot_index = r.release_slot;
            if (int'(r.release_slot) < SCA_SLOT_COUNT)
            begin
                pool_busy[r.release_slot]    = 1'b0;
                pool_run_len[r.release_slot] = '0;
                g.granted = 1'b1;
            end
            return g;
        end
        if (r.request_bytes < LIMIT_ONE)
            cls = int'(CLASS_ONE);
        else if (r.request_bytes <= LIMIT_TWO)
            cls = int'(CLASS_TWO);
        else if (r.request_bytes <= LIMIT_FOUR)
            cls = int'(CLASS_FOUR);
        else
            cls = int'(CLASS_EIGHT);
        idx = 0;
        while (idx < SCA_SLOT_COUNT)
        begin
            if (pool_busy[idx])
            begin
                idx += (cls < int'(pool_run_len[idx])) ? int'(pool_run_len[idx]) : cls;
            end
            else
            begin
                run_ok = 1'b1;
                for (k = 0; k < cls; k++)
                begin
                    // Slots past the end of the pool count as taken
                    if (idx + k >= SCA_SLOT_COUNT || pool_busy[idx + k])
                        run_ok = 1'b0;
                end
                if (run_ok)
                begin
                    pool_busy[idx]    = 1'b1;
                    pool_run_len[idx] = 4'(cls);
                    g.granted       = 1'b1;
                    g.slot_index    = 4'(idx);
                    g.block_address = pool_base + 32'(idx) * 32'(SCA_SLOT_BYTES);
                    return g;
                end
                idx += cls;
            end
        end
        // Scan ran off the end: no run fits, everything reads zero
        return g;
    endfunction

    // Build requests; the field the command ignores still carries random bits
    function automatic sca_req_t alloc_cmd(input logic [31:0] bytes);
        sca_req_t r;
        r.cmd           = CMD_ALLOC;
        r.request_bytes = bytes;
        r.release_slot  = 4'($urandom_range(0, 15));
        return r;
    endfunction

    function automatic sca_req_t release_cmd(input logic [3:0] slot);
        sca_req_t r;
        r.cmd           = CMD_RELEASE;
        r.request_bytes = $urandom;
        r.release_slot  = slot;
        return r;
    endfunction

    // Random mix: allocations spread over all four classes and their boundaries,
    // releases aimed mostly at heads that are currently busy so the pool churns
    function automatic sca_req_t random_cmd();
        logic [3:0]  heads[$];
        logic [31:0] bytes;
        int          s;
        if ($urandom_range(0, 99) < 58)
        begin
            case ($urandom_range(0, 9))
                0, 1, 2: bytes = $urandom_range(int'(LIMIT_ONE) - 1, 0);
                3, 4:    bytes = $urandom_range(int'(LIMIT_TWO), int'(LIMIT_ONE));
                5, 6:    bytes = $urandom_range(int'(LIMIT_FOUR), int'(LIMIT_TWO) + 1);
                7:       bytes = $urandom_range(32'hFFFF_FFFF, LIMIT_FOUR + 1);
                8:
                begin
                    case ($urandom_range(0, 7))
                        0:       bytes = '0;
                        1:       bytes = LIMIT_ONE - 1;
                        2:       bytes = LIMIT_ONE;
                        3:       bytes = LIMIT_TWO;
                        4:       bytes = LIMIT_TWO + 1;
                        5:       bytes = LIMIT_FOUR;
                        6:       bytes = LIMIT_FOUR + 1;
                        default: bytes = 32'hFFFF_FFFF;
                    endcase
                end
                default: bytes = $urandom;
            endcase
            return alloc_cmd(bytes);
        end
        for (s = 0; s < SCA_SLOT_COUNT; s++)
        begin
            if (pool_busy[s])
                heads.push_back(4'(s));
        end
        if (heads.size() != 0 && $urandom_range(0, 3) != 0)
            return release_cmd(heads[$urandom_range(0, heads.size() - 1)]);
        return release_cmd(4'($urandom_range(0, 15)));
    endfunction

    // Driver: a transaction is taken at an edge with start high and busy low.
    // Hold start and req while busy; after a take, either present the next
    // request at once or drop start and stay idle. Each signal gets one
    // assignment per edge so back-to-back requests keep start high.
    always @(posedge clk)
    begin : drive_requests
        logic     next_start;
        sca_req_t next_req;
        if (rst_n)
        begin
            next_start = start;
            next_req   = req;
            if (start && !busy)
            begin
                expected_grants.push_back(predict_grant(req));
                next_start = 1'b0;
            end
            if (!next_start && pending_cmds.size() != 0)
            begin
                if (!(idle_on && $urandom_range(0, 99) < IDLE_PCT))
                begin
                    next_req   = pending_cmds.pop_front();
                    next_start = 1'b1;
                end
            end
            start <= next_start;
            req   <= next_req;
        end
    end

    // Monitor: the done strobe lasts one cycle and cannot be stalled, so
    // check every strobed result against the oldest outcome still expected
    always @(posedge clk)
    begin : check_results
        sca_rsp_t want;
        if (rst_n && done)
        begin
            if (expected_grants.size() == 0)
            begin
                $error("result with nothing expected: granted %0b slot_index %0d block_address %h",
                       rsp.granted, rsp.slot_index, rsp.block_address);
                mismatch_count++;
            end
            else
            begin
                want = expected_grants.pop_front();
                if (rsp.granted !== want.granted)
                begin
                    $error("granted: expected %0b, actual %0b", want.granted, rsp.granted);
                    mismatch_count++;
                end
                if (rsp.slot_index !== want.slot_index)
                begin
                    $error("slot_index: expected %0d, actual %0d",
                           want.slot_index, rsp.slot_index);
                    mismatch_count++;
                end
                if (rsp.block_address !== want.block_address)
                begin
                    $error("block_address: expected %h, actual %h",
                           want.block_address, rsp.block_address);
                    mismatch_count++;
                end
            end
        end
    end

    // Watchdog: end the run if nothing moves for too long
    always @(posedge clk)
    begin : watchdog
        if ((start && !busy) || done || psel)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    // Wait until every request is taken and every result is back, then idle a bit
    task automatic settle();
        while (pending_cmds.size() != 0 || start || busy || expected_grants.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // APB write of base_address: setup cycle, then access cycle; pready is tied high,
    // so the register takes the value at the edge that ends the access cycle
    task automatic write_base(input logic [31:0] value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= REG_BASE_ADDRESS;
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        pool_base = value;
    endtask

    // Keep the request queue topped up so the shadow pool stays close to the
    // state the release picker sees
    task automatic run_random(input int count);
        int i;
        for (i = 0; i < count; i++)
        begin
            while (pending_cmds.size() >= 2)
                @(posedge clk);
            pending_cmds.push_back(random_cmd());
        end
    endtask

    initial
    begin : stimulus
        int s;
        for (s = 0; s < SCA_SLOT_COUNT; s++)
        begin
            pool_busy[s]    = 1'b0;
            pool_run_len[s] = '0;
        end
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part at the reset base of zero.
        // Walk every class boundary; classes 2 and 4 skip over busy heads.
        pending_cmds.push_back(alloc_cmd(32'h0));
        pending_cmds.push_back(alloc_cmd(LIMIT_ONE - 1));
        pending_cmds.push_back(alloc_cmd(LIMIT_ONE));
        pending_cmds.push_back(alloc_cmd(LIMIT_TWO));
        pending_cmds.push_back(alloc_cmd(LIMIT_TWO + 1));
        pending_cmds.push_back(alloc_cmd(LIMIT_FOUR));
        // Eight-slot runs cannot fit now: allocation fails, largest size maps to eight
        pending_cmds.push_back(alloc_cmd(LIMIT_FOUR + 1));
        pending_cmds.push_back(alloc_cmd(32'hFFFF_FFFF));
        // Release of a slot that holds nothing is still granted
        pending_cmds.push_back(release_cmd(4'd15));
        // Free two single heads and reuse the space for a pair
        pending_cmds.push_back(release_cmd(4'd0));
        pending_cmds.push_back(release_cmd(4'd1));
        pending_cmds.push_back(alloc_cmd(32'h0000_8000));
        // Free a quad, then a pair lands after three busy pair heads
        pending_cmds.push_back(release_cmd(4'd8));
        pending_cmds.push_back(alloc_cmd(LIMIT_ONE));
        pending_cmds.push_back(alloc_cmd(LIMIT_FOUR + 1));
        // Empty the pool and fill it with two eight-slot runs, then one more fails
        pending_cmds.push_back(release_cmd(4'd0));
        pending_cmds.push_back(release_cmd(4'd2));
        pending_cmds.push_back(release_cmd(4'd4));
        pending_cmds.push_back(release_cmd(4'd6));
        pending_cmds.push_back(release_cmd(4'd12));
        pending_cmds.push_back(alloc_cmd(32'h0002_0000));
        pending_cmds.push_back(alloc_cmd(LIMIT_FOUR + 1));
        pending_cmds.push_back(alloc_cmd(32'h1));
        settle();

        // Random phases across base settings, the extremes among them.
        // The all-ones base wraps every address past slot 0.
        write_base(32'hFFFF_FFFF);
        run_random(100);
        settle();

        // Long stretch with back-to-back transactions
        write_base($urandom);
        idle_on = 1'b0;
        run_random(150);
        settle();
        idle_on = 1'b1;

        write_base(32'h0);
        run_random(100);
        settle();

        write_base(32'hFFFF_8000);
        run_random(150);
        settle();

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && expected_grants.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

// ===== size_class_slot_allocator_core.f =====
+incdir+rtl/core
rtl/core/sca_pkg.sv
rtl/core/sca_slot_table.sv
rtl/core/size_class_slot_allocator_core.sv
tb/size_class_slot_allocator_core_tb.sv
